// ===== rtl/nd_index_stepper_defines.svh =====
// Assertion macros shared by the nd_index_stepper checker.
// Included by bare file name; holds nothing but macro definitions.
`ifndef ND_INDEX_STEPPER_DEFINES_SVH
`define ND_INDEX_STEPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nd_index_stepper check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nd_index_stepper check failed");

`endif

// ===== rtl/nis_pkg.sv =====
// Shared constants, types and helpers for the nd_index_stepper block.
// No dependencies; imported by nis_cfg, nis_front, nis_div_cell and the top level.
package nis_pkg;

    localparam int NUM_DIMS         = 4;
    localparam int IDX_W            = 16;
    localparam int STEP_W           = 32;
    localparam int VAL_W            = 64;
    localparam int RANK_W           = 3;
    localparam int DEFAULT_MAX_RANK = 4;
    localparam int CFG_ADDR_W       = 5;
    localparam int APB_DATA_W       = 32;
    localparam int NUM_CELLS        = NUM_DIMS * VAL_W;
    localparam int PP_SPLIT         = 24;

    typedef logic [NUM_DIMS-1:0][IDX_W-1:0] t_idx_vec;

    typedef enum logic [2:0] {
        REG_RANK  = 3'd0,
        REG_SIZE0 = 3'd1,
        REG_SIZE1 = 3'd2,
        REG_SIZE2 = 3'd3,
        REG_SIZE3 = 3'd4
    } t_reg_idx;

    // Effective configuration: rank clamped, zero sizes read as one.
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        t_idx_vec          size;
    } t_cfg;

    typedef struct packed {
        t_idx_vec idx;
        t_idx_vec digit;
        logic     zero;
        logic     ovf;
        logic     unf;
    } t_side;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] rem;
        logic [VAL_W-1:0] dq;
        t_side            side;
    } t_cell;

    function automatic logic dim_used(input int j, input logic [RANK_W-1:0] rank);
        return (j + int'(rank)) >= NUM_DIMS;
    endfunction

endpackage

// ===== rtl/nis_cfg.sv =====
// APB register file for nd_index_stepper: rank and the four dimension sizes.
// Depends on nis_pkg.
module nis_cfg #(
    parameter int MAX_RANK = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nis_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [nis_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nis_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output nis_pkg::t_cfg                  o_cfg
);
    import nis_pkg::*;

    localparam int RANK_LIM = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;

    logic [RANK_W-1:0] r_rank;
    t_idx_vec          r_size;
    t_reg_idx          w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= RANK_W'(4);
            r_size <= {NUM_DIMS{IDX_W'(1)}};
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RANK:  r_rank    <= pwdata[RANK_W-1:0];
                REG_SIZE0: r_size[0] <= pwdata[IDX_W-1:0];
                REG_SIZE1: r_size[1] <= pwdata[IDX_W-1:0];
                REG_SIZE2: r_size[2] <= pwdata[IDX_W-1:0];
                REG_SIZE3: r_size[3] <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RANK:  prdata = APB_DATA_W'(r_rank);
            REG_SIZE0: prdata = APB_DATA_W'(r_size[0]);
            REG_SIZE1: prdata = APB_DATA_W'(r_size[1]);
            REG_SIZE2: prdata = APB_DATA_W'(r_size[2]);
            REG_SIZE3: prdata = APB_DATA_W'(r_size[3]);
            default:   prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.rank = (int'(r_rank) > RANK_LIM) ? RANK_W'(RANK_LIM) : r_rank;
        for (int j = 0; j < NUM_DIMS; j++) begin
            o_cfg.size[j] = (r_size[j] == '0) ? IDX_W'(1) : r_size[j];
        end
    end

endmodule

// ===== rtl/nis_front.sv =====
// Front pipeline of nd_index_stepper: linear value, capacity, step add and range check.
// Depends on nis_pkg; feeds the first division cell.
module nis_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [nis_pkg::STEP_W-1:0] i_step,
    input  nis_pkg::t_idx_vec          i_idx,
    input  nis_pkg::t_cfg              i_cfg,
    output nis_pkg::t_cell             o_cell
);
    import nis_pkg::*;

    localparam int NST = 6;

    logic     [NST-1:0]             r_v;
    t_idx_vec                       r_idx  [NST];
    logic                           r_zero [NST];
    logic                           r_neg  [NST];
    logic     [STEP_W-1:0]          r_mag  [NST];

    logic [31:0]            r_a1, r_c1;
    logic [47:0]            r_a2, r_c2;
    logic [39:0]            r_apl, r_aph, r_cpl, r_cph;
    logic [VAL_W-1:0]       r_lin, r_cap3, r_cap4;
    logic [VAL_W:0]         r_val;
    logic                   r_unf4, r_unf5, r_ovf5;
    logic [VAL_W-1:0]       r_val5;

    logic [STEP_W-1:0]      w_mag;
    t_idx_vec               w_ei_in, w_es;
    logic [IDX_W-1:0]       w_ei2, w_ei3;
    logic [31:0]            w_a1, w_c1;
    logic [47:0]            w_a2, w_c2;
    logic [39:0]            w_apl, w_aph, w_cpl, w_cph;
    logic [VAL_W-1:0]       w_lin, w_cap;
    logic [VAL_W:0]         w_val;

    assign w_mag = i_step[STEP_W-1] ? (~i_step + STEP_W'(1)) : i_step;

    // Unused outer dimensions enter the math as index zero and size one.
    always_comb begin
        for (int j = 0; j < NUM_DIMS; j++) begin
            w_ei_in[j] = dim_used(j, i_cfg.rank) ? i_idx[j] : '0;
            w_es[j]    = dim_used(j, i_cfg.rank) ? i_cfg.size[j] : IDX_W'(1);
        end
        w_ei2 = dim_used(2, i_cfg.rank) ? r_idx[0][2] : '0;
        w_ei3 = dim_used(3, i_cfg.rank) ? r_idx[2][3] : '0;
    end

    assign w_a1  = w_ei_in[0] * w_es[1] + 32'(w_ei_in[1]);
    assign w_c1  = w_es[0] * w_es[1];
    assign w_a2  = r_a1 * w_es[2] + 48'(w_ei2);
    assign w_c2  = r_c1 * w_es[2];
    assign w_apl = r_a2[PP_SPLIT-1:0] * w_es[3];
    assign w_aph = r_a2[47:PP_SPLIT] * w_es[3];
    assign w_cpl = r_c2[PP_SPLIT-1:0] * w_es[3];
    assign w_cph = r_c2[47:PP_SPLIT] * w_es[3];
    assign w_lin = {r_aph, PP_SPLIT'(0)} + VAL_W'(r_apl) + VAL_W'(w_ei3);
    assign w_cap = {r_cph, PP_SPLIT'(0)} + VAL_W'(r_cpl);
    assign w_val = r_neg[3] ? ({1'b0, r_lin} - (VAL_W+1)'(r_mag[3]))
                            : ({1'b0, r_lin} + (VAL_W+1)'(r_mag[3]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx[0]  <= i_idx;
            r_zero[0] <= (i_step == '0);
            r_neg[0]  <= i_step[STEP_W-1];
            r_mag[0]  <= w_mag;
            for (int s = 1; s < NST; s++) begin
                r_idx[s]  <= r_idx[s-1];
                r_zero[s] <= r_zero[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_mag[s]  <= r_mag[s-1];
            end
            r_a1   <= w_a1;
            r_c1   <= w_c1;
            r_a2   <= w_a2;
            r_c2   <= w_c2;
            r_apl  <= w_apl;
            r_aph  <= w_aph;
            r_cpl  <= w_cpl;
            r_cph  <= w_cph;
            r_lin  <= w_lin;
            r_cap3 <= w_cap;
            r_val  <= w_val;
            r_unf4 <= r_neg[3] && w_val[VAL_W];
            r_cap4 <= r_cap3;
            r_val5 <= r_val[VAL_W-1:0];
            r_unf5 <= r_unf4;
            r_ovf5 <= !r_neg[4] && (r_val >= {1'b0, r_cap4});
        end
    end

    always_comb begin
        o_cell.valid      = r_v[NST-1];
        o_cell.rem        = '0;
        o_cell.dq         = r_val5;
        o_cell.side.idx   = r_idx[NST-1];
        o_cell.side.digit = '0;
        o_cell.side.zero  = r_zero[NST-1];
        o_cell.side.ovf   = r_ovf5;
        o_cell.side.unf   = r_unf5;
    end

endmodule

// ===== rtl/nis_div_cell.sv =====
// One restoring-division cell: develops one quotient bit and passes the result on.
// Depends on nis_pkg; chained in the nd_index_stepper top level.
module nis_div_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  nis_pkg::t_cell            i_cell,
    input  logic [nis_pkg::IDX_W-1:0] i_divisor,
    output nis_pkg::t_cell            o_cell
);
    import nis_pkg::*;

    logic             r_valid;
    logic [IDX_W-1:0] r_rem;
    logic [VAL_W-1:0] r_dq;
    t_side            r_side;

    logic [IDX_W:0]   w_trial;
    logic [IDX_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {i_cell.rem, i_cell.dq[VAL_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_ge ? w_diff[IDX_W-1:0] : w_trial[IDX_W-1:0];
            r_dq   <= {i_cell.dq[VAL_W-2:0], w_ge};
            r_side <= i_cell.side;
        end
    end

    always_comb begin
        o_cell.valid = r_valid;
        o_cell.rem   = r_rem;
        o_cell.dq    = r_dq;
        o_cell.side  = r_side;
    end

endmodule

// ===== rtl/nd_index_stepper.sv =====
// Top level of nd_index_stepper: APB registers, front pipeline, division cell chain.
// Depends on nis_pkg, nis_cfg, nis_front and nis_div_cell.
//
// Adds a signed step to a tensor index over the innermost rank dimensions and
// returns the new index with an in-range flag. The block takes one transfer per
// clock and returns one result per clock while not stalled. Four 64-cell
// restoring-division chains (one quotient bit per cell) turn the sum back into
// digits after the front pipeline. The whole pipeline stalls only while a result
// is waiting at the output and the last cell holds another one. Configuration is
// read live by every stage, so it must be written only while no transfer is in
// flight.
module nd_index_stepper #(
    parameter int MAX_RANK = nis_pkg::DEFAULT_MAX_RANK
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nis_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [nis_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nis_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: step[31:0], in_index_0, in_index_1, in_index_2, in_index_3
    input  logic [95:0]                    s_axis_tdata,
    // Output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: out_index_0, out_index_1, out_index_2, out_index_3
    output logic [63:0]                    m_axis_tdata,
    // Fields from bit 0: ok
    output logic [0:0]                     m_axis_tuser
);
    import nis_pkg::*;

    t_cfg     w_cfg;
    t_cell    w_front;
    t_cell    w_cin  [NUM_CELLS];
    t_cell    w_cout [NUM_CELLS];
    t_cell    w_last;
    t_idx_vec w_in_idx;
    t_idx_vec w_dig;
    t_idx_vec n_out_idx;
    logic     n_ok;
    logic     w_out_load;
    logic     w_en;

    logic     r_out_valid;
    t_idx_vec r_out_idx;
    logic     r_out_ok;

    nis_cfg #(.MAX_RANK(MAX_RANK)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    always_comb begin
        for (int j = 0; j < NUM_DIMS; j++) begin
            w_in_idx[j] = s_axis_tdata[STEP_W + j*IDX_W +: IDX_W];
        end
    end

    nis_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_step  (s_axis_tdata[STEP_W-1:0]),
        .i_idx   (w_in_idx),
        .i_cfg   (w_cfg),
        .o_cell  (w_front)
    );

    // Division d works on dimension NUM_DIMS-1-d; at each boundary the quotient
    // moves on as the next dividend and the remainder is kept as a digit.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_cin[k] = w_front;
        end else if ((k % VAL_W) == 0) begin : g_bound
            always_comb begin
                w_cin[k] = w_cout[k-1];
                w_cin[k].rem = '0;
                w_cin[k].side.digit[NUM_DIMS - k/VAL_W] = w_cout[k-1].rem;
            end
        end else begin : g_link
            assign w_cin[k] = w_cout[k-1];
        end

        nis_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_cell    (w_cin[k]),
            .i_divisor (w_cfg.size[NUM_DIMS-1-k/VAL_W]),
            .o_cell    (w_cout[k])
        );
    end

    assign w_last     = w_cout[NUM_CELLS-1];
    assign w_out_load = !r_out_valid || m_axis_tready;
    assign w_en       = w_out_load || !w_last.valid;

    always_comb begin
        w_dig    = w_last.side.digit;
        w_dig[0] = w_last.rem;
        for (int j = 0; j < NUM_DIMS; j++) begin
            if (w_last.side.zero || !dim_used(j, w_cfg.rank)) begin
                n_out_idx[j] = w_last.side.idx[j];
            end else if (w_last.side.ovf) begin
                n_out_idx[j] = '0;
            end else if (w_last.side.unf) begin
                n_out_idx[j] = w_cfg.size[j] - IDX_W'(1);
            end else begin
                n_out_idx[j] = w_dig[j];
            end
        end
        n_ok = w_last.side.zero ||
               (!w_last.side.ovf && !w_last.side.unf && (w_cfg.rank != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && w_last.valid) begin
            r_out_idx <= n_out_idx;
            r_out_ok  <= n_ok;
        end
    end

    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_idx;
    assign m_axis_tuser  = r_out_ok;

endmodule

// ===== rtl/nis_checker.sv =====
// Port-level checks for nd_index_stepper, bound to the top level.
// Depends on nd_index_stepper_defines.svh.
`include "nd_index_stepper_defines.svh"

module nis_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // The input side only stalls when a finished result is held at the output.
    `NIS_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // Nothing leaves the block on the cycle after reset.
    `NIS_ASSERT_IMPLY(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !m_axis_tvalid)

    // A waiting result keeps its payload until its transfer.
    `NIS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind nd_index_stepper nis_checker u_nis_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
